// File: rtl/core/hsv_hue_breathing_animator_macros.svh
// Assertion macros shared by the animator RTL.
`ifndef HSV_HUE_BREATHING_ANIMATOR_MACROS_SVH
`define HSV_HUE_BREATHING_ANIMATOR_MACROS_SVH

// Check a property on every rising edge of i_clk outside reset.
`define HSVBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define HSVBA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/hsvba_pkg.sv
// Package: widths, constants and register codes of the hue breathing animator.
package hsvba_pkg;

    localparam int NOW_W   = 32;
    localparam int HUE_W   = 16;
    localparam int STEP_W  = 10;
    localparam int VAL_W   = 14;
    localparam int DLY_W   = 16;
    localparam int CHAN_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int TICK_WIDTH_DEF = 32;

    // channel unit: value (14 bit) times multiplier (13 bit), times 255, over 6e7
    localparam int MULT_W = 13;
    localparam int PROD_W = VAL_W + MULT_W;
    localparam int NUM_W  = PROD_W + CHAN_W;
    localparam int QUO_W  = CHAN_W + 1;

    localparam logic [HUE_W-1:0]  HUE_FULL   = 16'd36000;
    localparam logic [HUE_W-1:0]  HUE_SECTOR = 16'd6000;
    localparam logic [NUM_W-1:0]  DIV_ONE    = 35'd60000000;

    localparam logic [HUE_W-1:0]  RST_HUE_LOW    = 16'd22000;
    localparam logic [HUE_W-1:0]  RST_HUE_HIGH   = 16'd26000;
    localparam logic [STEP_W-1:0] RST_HUE_STEP   = 10'd1;
    localparam logic [VAL_W-1:0]  RST_VALUE_MAX  = 14'd5000;
    localparam logic [VAL_W-1:0]  RST_VALUE_STEP = 14'd1;
    localparam logic [DLY_W-1:0]  RST_IDLE_DELAY = 16'd5000;
    localparam logic [HUE_W-1:0]  RST_HUE_NOW    = 16'd24000;
    localparam logic [VAL_W-1:0]  RST_BRIGHT     = 14'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_LOW    = 3'd0,
        CFG_HUE_HIGH   = 3'd1,
        CFG_HUE_STEP   = 3'd2,
        CFG_VALUE_MAX  = 3'd3,
        CFG_VALUE_STEP = 3'd4,
        CFG_IDLE_DELAY = 3'd5
    } t_cfg_idx;

endpackage

// File: rtl/core/hsv_hue_breathing_animator.sv
// Top level: HSV hue breathing animator for one RGB LED.
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------
//  in      | i_in_valid / o_in_ready   | i_action, i_now_ms
//  out     | o_out_valid / i_out_ready | o_red, o_green, o_blue
//  cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An off item goes straight to FINISH. An idle item runs the bit-serial timer
// compare, the hue sector search, and then the three parallel channel units
// (a 13-bit multiply, a scale and a 9-bit divide, plus start and hand-over).
// An idle item before the delay has passed ends after the timer compare.
// One item is worked on at a time; the next is taken once the result sits in
// the output register. A stalled output holds the next result in FINISH.
// Reset is synchronous and needs no clearing pass; cfg is always ready.
module hsv_hue_breathing_animator
    import hsvba_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [NOW_W-1:0]      i_now_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_W-1:0]     o_red,
    output logic [CHAN_W-1:0]     o_green,
    output logic [CHAN_W-1:0]     o_blue,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "hsv_hue_breathing_animator_macros.svh"

    localparam int CNT_W    = $clog2(TICK_WIDTH);
    localparam int NOW_TAKE = (TICK_WIDTH < NOW_W) ? TICK_WIDTH : NOW_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TIMER,
        S_REDUCE,
        S_CONVERT,
        S_FINISH
    } t_state;

    // configuration registers
    logic [HUE_W-1:0]  r_hue_low;
    logic [HUE_W-1:0]  r_hue_high;
    logic [STEP_W-1:0] r_hue_step;
    logic [VAL_W-1:0]  r_value_max;
    logic [VAL_W-1:0]  r_value_step;
    logic [DLY_W-1:0]  r_idle_delay;

    // animation state
    logic [HUE_W-1:0]      r_hue;
    logic                  r_falling;
    logic [VAL_W-1:0]      r_bright;
    logic [TICK_WIDTH-1:0] r_idle_start;

    // sequencer and datapath
    t_state                r_state;
    logic                  r_act;
    logic [CNT_W-1:0]      r_bit_cnt;
    logic [TICK_WIDTH-1:0] r_sh_a;
    logic [TICK_WIDTH-1:0] r_sh_d;
    logic [TICK_WIDTH-1:0] r_sh_b;
    logic                  r_carry;
    logic                  r_lt;
    logic [HUE_W-1:0]      r_hw;
    logic [2:0]            r_sector;
    logic                  r_chan_start;
    logic [CHAN_W-1:0]     r_res_r;
    logic [CHAN_W-1:0]     r_res_g;
    logic [CHAN_W-1:0]     r_res_b;
    logic                  r_out_valid;

    logic [TICK_WIDTH-1:0] w_now;
    logic                  w_sum_bit;
    logic                  w_carry_nx;
    logic                  w_lt_nx;
    logic [MULT_W-1:0]     w_rem;
    logic [MULT_W-1:0]     w_m_fall;
    logic                  w_done_full;
    logic                  w_done_rise;
    logic                  w_done_fall;
    logic [CHAN_W-1:0]     w_full;
    logic [CHAN_W-1:0]     w_rise;
    logic [CHAN_W-1:0]     w_fall;
    logic [HUE_W:0]        w_hue_sum;
    logic [HUE_W-1:0]      w_hue_up;
    logic [HUE_W-1:0]      w_hue_dn;
    logic [HUE_W-1:0]      w_hue_new;
    logic                  w_turn;
    logic [VAL_W:0]        w_bright_sum;
    logic                  w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    assign w_now = TICK_WIDTH'(i_now_ms[NOW_TAKE-1:0]);

    // serial adder of start and delay, LSB first, with a running compare to now
    assign w_sum_bit  = r_sh_a[0] ^ r_sh_d[0] ^ r_carry;
    assign w_carry_nx = (r_sh_a[0] & r_sh_d[0]) | (r_sh_a[0] & r_carry)
                        | (r_sh_d[0] & r_carry);
    assign w_lt_nx    = (w_sum_bit != r_sh_b[0]) ? r_sh_b[0] : r_lt;

    assign w_rem    = r_hw[MULT_W-1:0];
    assign w_m_fall = HUE_SECTOR[MULT_W-1:0] - w_rem;

    // hue and brightness steps, applied when an idle result leaves
    assign w_hue_sum = {1'b0, r_hue} + (HUE_W+1)'(r_hue_step);
    assign w_hue_up  = w_hue_sum[HUE_W] ? {HUE_W{1'b1}} : w_hue_sum[HUE_W-1:0];
    assign w_hue_dn  = (HUE_W'(r_hue_step) > r_hue) ? '0 : r_hue - HUE_W'(r_hue_step);
    assign w_hue_new = r_falling ? w_hue_dn : w_hue_up;
    assign w_turn    = (w_hue_new > r_hue_high) || (w_hue_new < r_hue_low);
    assign w_bright_sum = {1'b0, r_bright} + {1'b0, r_value_step};

    assign w_out_free = !r_out_valid || i_out_ready;

    // full uses 6000 as multiplier: v*6000*255/6e7 is v*255/1e4 exactly
    hsvba_chan u_full (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_chan_start),
        .i_value (r_bright),
        .i_mult  (HUE_SECTOR[MULT_W-1:0]),
        .o_done  (w_done_full),
        .o_level (w_full)
    );

    hsvba_chan u_rise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_chan_start),
        .i_value (r_bright),
        .i_mult  (w_rem),
        .o_done  (w_done_rise),
        .o_level (w_rise)
    );

    hsvba_chan u_fall (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_chan_start),
        .i_value (r_bright),
        .i_mult  (w_m_fall),
        .o_done  (w_done_fall),
        .o_level (w_fall)
    );

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low    <= RST_HUE_LOW;
            r_hue_high   <= RST_HUE_HIGH;
            r_hue_step   <= RST_HUE_STEP;
            r_value_max  <= RST_VALUE_MAX;
            r_value_step <= RST_VALUE_STEP;
            r_idle_delay <= RST_IDLE_DELAY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HUE_LOW:    r_hue_low    <= i_cfg_data[HUE_W-1:0];
                CFG_HUE_HIGH:   r_hue_high   <= i_cfg_data[HUE_W-1:0];
                CFG_HUE_STEP:   r_hue_step   <= i_cfg_data[STEP_W-1:0];
                CFG_VALUE_MAX:  r_value_max  <= i_cfg_data[VAL_W-1:0];
                CFG_VALUE_STEP: r_value_step <= i_cfg_data[VAL_W-1:0];
                CFG_IDLE_DELAY: r_idle_delay <= i_cfg_data[DLY_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, animation state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_chan_start <= 1'b0;
            r_hue        <= RST_HUE_NOW;
            r_falling    <= 1'b0;
            r_bright     <= RST_BRIGHT;
            r_idle_start <= '0;
        end else begin
            r_chan_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act <= i_action;
                        if (!i_action) begin
                            // off: black, restart the timer, drop brightness
                            r_idle_start <= w_now;
                            r_bright     <= '0;
                            r_res_r      <= '0;
                            r_res_g      <= '0;
                            r_res_b      <= '0;
                            r_state      <= S_FINISH;
                        end else begin
                            r_sh_a    <= r_idle_start;
                            r_sh_d    <= TICK_WIDTH'(r_idle_delay);
                            r_sh_b    <= w_now;
                            r_carry   <= 1'b0;
                            r_lt      <= 1'b0;
                            r_bit_cnt <= CNT_W'(TICK_WIDTH - 1);
                            r_state   <= S_TIMER;
                        end
                    end
                end
                S_TIMER: begin
                    r_sh_a  <= r_sh_a >> 1;
                    r_sh_d  <= r_sh_d >> 1;
                    r_sh_b  <= r_sh_b >> 1;
                    r_carry <= w_carry_nx;
                    r_lt    <= w_lt_nx;
                    if (r_bit_cnt == '0) begin
                        // delay passed: go on to the hue; not yet passed: drop the item without a result
                        if (w_lt_nx) begin
                            r_hw     <= r_hue;
                            r_sector <= '0;
                            r_state  <= S_REDUCE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_bit_cnt <= r_bit_cnt - 1'b1;
                    end
                end
                S_REDUCE: begin
                    // fold a full turn once, then count sectors
                    if (r_hw >= HUE_FULL) begin
                        r_hw <= r_hw - HUE_FULL;
                    end else if (r_hw >= HUE_SECTOR) begin
                        r_hw     <= r_hw - HUE_SECTOR;
                        r_sector <= r_sector + 1'b1;
                    end else begin
                        r_chan_start <= 1'b1;
                        r_state      <= S_CONVERT;
                    end
                end
                S_CONVERT: begin
                    if (w_done_full) begin
                        unique case (r_sector)
                            3'd0: begin
                                r_res_r <= w_full; r_res_g <= w_rise; r_res_b <= '0;
                            end
                            3'd1: begin
                                r_res_r <= w_fall; r_res_g <= w_full; r_res_b <= '0;
                            end
                            3'd2: begin
                                r_res_r <= '0; r_res_g <= w_full; r_res_b <= w_rise;
                            end
                            3'd3: begin
                                r_res_r <= '0; r_res_g <= w_fall; r_res_b <= w_full;
                            end
                            3'd4: begin
                                r_res_r <= w_rise; r_res_g <= '0; r_res_b <= w_full;
                            end
                            default: begin
                                r_res_r <= w_full; r_res_g <= '0; r_res_b <= w_fall;
                            end
                        endcase
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        o_red       <= r_res_r;
                        o_green     <= r_res_g;
                        o_blue      <= r_res_b;
                        r_out_valid <= 1'b1;
                        if (r_act) begin
                            r_hue <= w_hue_new;
                            if (w_turn) begin
                                r_falling <= !r_falling;
                            end
                            if (r_bright < r_value_max) begin
                                r_bright <= w_bright_sum[VAL_W] ? {VAL_W{1'b1}}
                                                                : w_bright_sum[VAL_W-1:0];
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `HSVBA_ASSERT(a_load_from_finish, $rose(r_out_valid) |-> $past(r_state == S_FINISH), "result loaded outside FINISH")
    `HSVBA_ASSERT(a_off_clears_value, (i_in_valid && o_in_ready && !i_action) |=> (r_bright == '0), "off item left brightness")
    `HSVBA_ASSERT(a_lanes_in_step, (w_done_full == w_done_rise) && (w_done_rise == w_done_fall), "channel units out of step")
    `HSVBA_ASSERT(a_convert_to_finish, (r_state == S_CONVERT && w_done_full) |=> (r_state == S_FINISH), "conversion not handed over")

endmodule

// File: rtl/core/hsvba_chan.sv
// Channel level unit: bit-serial floor(value * mult * 255 / 6e7), saturated to 8 bits.
module hsvba_chan
    import hsvba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [MULT_W-1:0] i_mult,
    output logic              o_done,
    output logic [CHAN_W-1:0] o_level
);

    localparam int CNT_W = $clog2(MULT_W);
    localparam logic [NUM_W-2:0] DIV_TOP = DIV_ONE[NUM_W-2:0] << (QUO_W - 1);

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_SCALE,
        C_DIV
    } t_phase;

    t_phase             r_phase;
    logic [CNT_W-1:0]   r_cnt;
    logic [VAL_W-1:0]   r_value;
    logic [MULT_W-1:0]  r_mult;
    logic [PROD_W-1:0]  r_prod;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-2:0]   r_div;
    logic [QUO_W-1:0]   r_quo;
    logic               w_fit;

    assign w_fit   = (r_num >= {1'b0, r_div});
    assign o_level = (|r_quo[QUO_W-1:CHAN_W]) ? {CHAN_W{1'b1}} : r_quo[CHAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= C_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_phase)
                C_IDLE: begin
                    if (i_start) begin
                        r_value <= i_value;
                        r_mult  <= i_mult;
                        r_prod  <= '0;
                        r_cnt   <= CNT_W'(MULT_W - 1);
                        r_phase <= C_MUL;
                    end
                end
                C_MUL: begin
                    // multiplier MSB first: shift the sum, add value on a one
                    r_prod <= {r_prod[PROD_W-2:0], 1'b0}
                              + (r_mult[MULT_W-1] ? PROD_W'(r_value) : '0);
                    r_mult <= {r_mult[MULT_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_phase <= C_SCALE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                C_SCALE: begin
                    // times 255 as times 256 less one
                    r_num   <= (NUM_W'(r_prod) << CHAN_W) - NUM_W'(r_prod);
                    r_div   <= DIV_TOP;
                    r_quo   <= '0;
                    r_cnt   <= CNT_W'(QUO_W - 1);
                    r_phase <= C_DIV;
                end
                C_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (w_fit) begin
                        r_num <= r_num - {1'b0, r_div};
                    end
                    r_quo <= {r_quo[QUO_W-2:0], w_fit};
                    r_div <= r_div >> 1;
                    if (r_cnt == '0) begin
                        o_done  <= 1'b1;
                        r_phase <= C_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_phase <= C_IDLE;
            endcase
        end
    end

endmodule

// File: sim/testbench.sv
// Testbench of the hue breathing animator: directed table, then randomised phases.
`timescale 1ns / 100ps

module testbench;
    import hsvba_pkg::*;

    // Item codes on i_action
    localparam logic ACT_OFF  = 1'b0;
    localparam logic ACT_IDLE = 1'b1;

    // Register indexes past the end of the map: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Settling wait for an idle item that shows nothing to finish, with a margin on top
    localparam int SETTLE_CYCLES = 120;
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 180;
    localparam int MAX_REPORTS   = 40;

    localparam logic [VAL_W:0] BRIGHT_CEIL = 15'd16383;
    localparam logic [63:0]    VAL_ONE64   = 64'd10000;
    localparam logic [63:0]    DIV_ONE64   = {29'd0, DIV_ONE};

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // One data word per register, in register index order
    typedef struct packed {
        logic [CFG_DATA_W-1:0] hue_low;
        logic [CFG_DATA_W-1:0] hue_high;
        logic [CFG_DATA_W-1:0] hue_step;
        logic [CFG_DATA_W-1:0] value_max;
        logic [CFG_DATA_W-1:0] value_step;
        logic [CFG_DATA_W-1:0] idle_delay;
    } t_setting;

    typedef enum logic {ROW_ITEM, ROW_SETUP} t_row_kind;

    // A row of the directed table: either an item or a new register setting
    typedef struct {
        t_row_kind         kind;
        logic              act;
        logic [NOW_W-1:0]  now;
        bit                typed;
        bit                lit;
        t_rgb              rgb;
        t_setting          setting;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_action;
    logic [NOW_W-1:0]      i_now_ms;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [CHAN_W-1:0]     o_red;
    logic [CHAN_W-1:0]     o_green;
    logic [CHAN_W-1:0]     o_blue;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Typed expectation travelling alongside a directed item
    bit   tag_typed;
    bit   tag_lit;
    t_rgb tag_rgb;

    // Registers as the predictor sees them
    logic [HUE_W-1:0]  c_hue_low;
    logic [HUE_W-1:0]  c_hue_high;
    logic [STEP_W-1:0] c_hue_step;
    logic [VAL_W-1:0]  c_value_max;
    logic [VAL_W-1:0]  c_value_step;
    logic [DLY_W-1:0]  c_idle_delay;

    // Animation state as the predictor sees it
    logic [HUE_W-1:0] m_hue;
    bit               m_falling;
    logic [VAL_W-1:0] m_bright;
    logic [NOW_W-1:0] m_start;

    t_rgb rgb_due[$];
    t_row plan[$];

    int send_idle_pct;
    int out_stall_pct;
    bit hold_req;
    int hold_left;
    int fail_count;
    int items_in;
    int results_seen;
    int cfg_writes;
    int phases_run;

    bit   mon_lit;
    t_rgb mon_rgb;
    t_rgb mon_got;
    t_rgb mon_want;

    hsv_hue_breathing_animator #(
        .TICK_WIDTH(TICK_WIDTH_DEF)
    ) i_dut (.*);

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [CHAN_W-1:0] clip(input logic [63:0] x);
        return (x > 64'd255) ? 8'hFF : x[CHAN_W-1:0];
    endfunction

    // Work out what one accepted item shows on the LED and advance the animation.
    // The tick compare is done at 32 bits, the width the block is built with here.
    task automatic animate_led(input logic act, input logic [NOW_W-1:0] now,
                               output bit lit, output t_rgb rgb);
        logic [NOW_W-1:0]  deadline;
        logic [HUE_W-1:0]  hw;
        logic [HUE_W-1:0]  rem;
        logic [HUE_W-1:0]  sector;
        logic [63:0]       v;
        logic [CHAN_W-1:0] ch_full;
        logic [CHAN_W-1:0] ch_rise;
        logic [CHAN_W-1:0] ch_fall;
        logic [HUE_W:0]    up;
        logic [VAL_W:0]    nb;
        lit = 1'b0;
        rgb = '0;
        if (act == ACT_OFF) begin
            // Go dark and restart the idle timer
            lit      = 1'b1;
            m_start  = now;
            m_bright = '0;
        end else begin
            deadline = m_start + {16'd0, c_idle_delay};
            if (deadline < now) begin
                lit     = 1'b1;
                v       = {50'd0, m_bright};
                hw      = m_hue % HUE_FULL;
                sector  = hw / HUE_SECTOR;
                rem     = hw % HUE_SECTOR;
                ch_full = clip(v * 255 / VAL_ONE64);
                ch_rise = clip(v * {48'd0, rem} * 255 / DIV_ONE64);
                ch_fall = clip(v * {48'd0, HUE_SECTOR - rem} * 255 / DIV_ONE64);
                case (sector)
                    16'd0:   rgb = {ch_full, ch_rise, 8'd0};
                    16'd1:   rgb = {ch_fall, ch_full, 8'd0};
                    16'd2:   rgb = {8'd0, ch_full, ch_rise};
                    16'd3:   rgb = {8'd0, ch_fall, ch_full};
                    16'd4:   rgb = {ch_rise, 8'd0, ch_full};
                    default: rgb = {ch_full, 8'd0, ch_fall};
                endcase
                // Step hue, clamping at both ends of the 16-bit range
                if (m_falling) begin
                    m_hue = ({6'd0, c_hue_step} > m_hue) ? '0 : m_hue - {6'd0, c_hue_step};
                end else begin
                    up    = {1'b0, m_hue} + {7'd0, c_hue_step};
                    m_hue = up[HUE_W] ? '1 : up[HUE_W-1:0];
                end
                if (m_hue > c_hue_high || m_hue < c_hue_low) begin
                    m_falling = !m_falling;
                end
                if (m_bright < c_value_max) begin
                    nb       = {1'b0, m_bright} + {1'b0, c_value_step};
                    m_bright = (nb > BRIGHT_CEIL) ? BRIGHT_CEIL[VAL_W-1:0] : nb[VAL_W-1:0];
                end
            end
        end
    endtask

    task automatic report_field(input string name, input logic [CHAN_W-1:0] want,
                                input logic [CHAN_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endtask

    // Watch all three channels at the rising edge: track the registers, predict
    // each accepted item and check each accepted result against the oldest due.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                case (i_cfg_index)
                    CFG_HUE_LOW:    c_hue_low    = i_cfg_data;
                    CFG_HUE_HIGH:   c_hue_high   = i_cfg_data;
                    CFG_HUE_STEP:   c_hue_step   = i_cfg_data[STEP_W-1:0];
                    CFG_VALUE_MAX:  c_value_max  = i_cfg_data[VAL_W-1:0];
                    CFG_VALUE_STEP: c_value_step = i_cfg_data[VAL_W-1:0];
                    CFG_IDLE_DELAY: c_idle_delay = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                items_in++;
                animate_led(i_action, i_now_ms, mon_lit, mon_rgb);
                // Directed rows with a value read off by hand override the predictor
                if (tag_typed) begin
                    mon_lit = tag_lit;
                    mon_rgb = tag_rgb;
                end
                if (mon_lit) begin
                    rgb_due.push_back(mon_rgb);
                end
            end
            if (o_out_valid && i_out_ready) begin
                mon_got = {o_red, o_green, o_blue};
                if (rgb_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: result with none expected, actual r %0d g %0d b %0d",
                                 $time, o_red, o_green, o_blue);
                    end
                end else begin
                    mon_want = rgb_due.pop_front();
                    results_seen++;
                    report_field("red", mon_want.red, mon_got.red);
                    report_field("green", mon_want.green, mon_got.green);
                    report_field("blue", mon_want.blue, mon_got.blue);
                end
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Offer one item, idling first at random; return at the falling edge after
    // acceptance with valid still high, so a back-to-back item keeps it raised.
    task automatic send_item(input logic act, input logic [NOW_W-1:0] now, input bit typed,
                             input bit lit, input t_rgb rgb);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_now_ms   <= now;
        tag_typed  <= typed;
        tag_lit    <= lit;
        tag_rgb    <= rgb;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Write one register; the caller drops valid after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Stop offering items and wait until every due result is in and any item
    // that shows nothing has had time to finish
    task automatic drain;
        i_in_valid <= 1'b0;
        while (rgb_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input t_setting s);
        drain();
        write_reg(CFG_HUE_LOW, s.hue_low);
        write_reg(CFG_HUE_HIGH, s.hue_high);
        write_reg(CFG_HUE_STEP, s.hue_step);
        write_reg(CFG_VALUE_MAX, s.value_max);
        write_reg(CFG_VALUE_STEP, s.value_step);
        write_reg(CFG_IDLE_DELAY, s.idle_delay);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_setting rand_setting();
        t_setting s;
        s.hue_low    = CFG_DATA_W'($urandom_range(65535));
        s.hue_high   = CFG_DATA_W'($urandom_range(65535));
        s.hue_step   = CFG_DATA_W'($urandom_range(65535));
        s.value_max  = CFG_DATA_W'($urandom_range(65535));
        s.value_step = CFG_DATA_W'($urandom_range(65535));
        s.idle_delay = CFG_DATA_W'($urandom_range(65535));
        return s;
    endfunction

    task automatic add_item(input logic act, input logic [NOW_W-1:0] now, input bit typed,
                            input bit lit, input t_rgb rgb);
        t_row row;
        row.kind    = ROW_ITEM;
        row.act     = act;
        row.now     = now;
        row.typed   = typed;
        row.lit     = lit;
        row.rgb     = rgb;
        row.setting = '0;
        plan.push_back(row);
    endtask

    task automatic add_setup(input t_setting s);
        t_row row;
        row.kind    = ROW_SETUP;
        row.act     = ACT_OFF;
        row.now     = '0;
        row.typed   = 1'b0;
        row.lit     = 1'b0;
        row.rgb     = '0;
        row.setting = s;
        plan.push_back(row);
    endtask

    // Pick a random item aimed at the current idle deadline: mostly updates that
    // animate, some right at the deadline, some anywhere, a few off items.
    task automatic pick_item(output logic act, output logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] deadline;
        int roll;
        deadline = m_start + {16'd0, c_idle_delay};
        roll     = $urandom_range(99);
        act      = ACT_IDLE;
        if (roll < 7) begin
            act = ACT_OFF;
            case ($urandom_range(2))
                0:       now = $urandom;
                1:       now = 32'hFFFF_FFFF - $urandom_range(70000);
                default: now = deadline + $urandom_range(20000);
            endcase
        end else if (roll < 13) begin
            now = $urandom;
        end else if (roll < 20) begin
            now = deadline - 1 + $urandom_range(2);
        end else begin
            now = deadline + 1 + $urandom_range(100000);
        end
    endtask

    task automatic run_phase(input t_setting s, input int send_pct, input int stall_pct,
                             input bit pressure);
        logic             act;
        logic [NOW_W-1:0] now;
        apply_setting(s);
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
        // Back the block up: hold the receiver while the sender keeps offering
        if (pressure) begin
            hold_req = 1'b1;
        end
        repeat (PHASE_ITEMS) begin
            pick_item(act, now);
            send_item(act, now, 1'b0, 1'b0, '0);
        end
        phases_run++;
    endtask

    // Watchdog: end the run if no channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        // Hold every input at a known value from time zero
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = ACT_OFF;
        i_now_ms      = '0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        tag_typed     = 1'b0;
        tag_lit       = 1'b0;
        tag_rgb       = '0;
        send_idle_pct = 0;
        out_stall_pct = 0;
        hold_req      = 1'b0;
        hold_left     = 0;
        fail_count    = 0;
        items_in      = 0;
        results_seen  = 0;
        cfg_writes    = 0;
        phases_run    = 0;

        // Predictor starts from the reset values
        c_hue_low    = RST_HUE_LOW;
        c_hue_high   = RST_HUE_HIGH;
        c_hue_step   = RST_HUE_STEP;
        c_value_max  = RST_VALUE_MAX;
        c_value_step = RST_VALUE_STEP;
        c_idle_delay = RST_IDLE_DELAY;
        m_hue        = RST_HUE_NOW;
        m_falling    = 1'b0;
        m_bright     = RST_BRIGHT;
        m_start      = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Writes past the register map must leave everything alone
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'hA5A5);
        i_cfg_valid <= 1'b0;

        // Straight after reset: the deadline is 5000 and the compare is strict
        add_item(ACT_IDLE, 32'd5000, 1'b1, 1'b0, '0);
        // Hue 240 degrees at half brightness: pure blue at 127
        add_item(ACT_IDLE, 32'd5001, 1'b1, 1'b1, {8'd0, 8'd0, 8'd127});
        add_item(ACT_IDLE, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        add_item(ACT_OFF, 32'd0, 1'b1, 1'b1, '0);
        // Off zeroes brightness, so the first update is black too
        add_item(ACT_IDLE, 32'd5001, 1'b1, 1'b1, '0);
        // Start at the top of the tick range: the deadline wraps to 4999
        add_item(ACT_OFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '0);
        add_item(ACT_IDLE, 32'd4999, 1'b1, 1'b0, '0);
        add_item(ACT_IDLE, 32'd5000, 1'b0, 1'b0, '0);

        // Full band, big hue steps, brightness driven past one into saturation
        add_setup('{16'd0, 16'd35999, 16'd1000, 16'd16383, 16'd10000, 16'd0});
        add_item(ACT_OFF, 32'd100, 1'b1, 1'b1, '0);
        add_item(ACT_IDLE, 32'd101, 1'b1, 1'b1, '0);
        for (int k = 0; k < 12; k++) begin
            // Walk hue up past 360 degrees and back
            add_item(ACT_IDLE, 32'd102 + k, 1'b0, 1'b0, '0);
        end

        // Longest delay: a start just below the wrap puts the deadline at the top
        add_setup('{16'd5000, 16'd65535, 16'hFFFF, 16'd0, 16'd0, 16'd65535});
        add_item(ACT_OFF, 32'hFFFF_0000, 1'b1, 1'b1, '0);
        add_item(ACT_IDLE, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_SETUP) begin
                apply_setting(plan[k].setting);
            end else begin
                send_item(plan[k].act, plan[k].now, plan[k].typed, plan[k].lit, plan[k].rgb);
            end
        end

        // Random phases: each its own setting and idling pattern
        run_phase('{16'd22000, 16'd26000, 16'd1, 16'd5000, 16'd1, 16'd5000}, 0, 0, 1'b0);
        run_phase('{16'd0, 16'd35999, 16'd1000, 16'd10000, 16'd250, 16'd0}, 83, 0, 1'b0);
        run_phase('{16'd1000, 16'd5000, 16'd997, 16'd16383, 16'd10000, 16'd65535}, 0, 83, 1'b1);
        run_phase('{16'd30000, 16'd65535, 16'hFFFF, 16'd3000, 16'd77, 16'd20}, 36, 36, 1'b0);
        run_phase(rand_setting(), 0, 0, 1'b0);
        run_phase('{16'd35999, 16'd0, 16'd500, 16'd0, 16'd0, 16'd1}, 83, 0, 1'b0);
        run_phase(rand_setting(), 0, 83, 1'b0);
        run_phase(rand_setting(), 36, 36, 1'b0);

        drain();

        $display("Run covered %0d items, %0d results checked, %0d register writes, %0d phases",
                 items_in, results_seen, cfg_writes, phases_run);
        $display("including wrapped deadlines, hue clamping, saturated brightness and a held output");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/hsvba_pkg.sv
rtl/core/hsvba_chan.sv
rtl/core/hsv_hue_breathing_animator.sv
sim/testbench.sv
